// ----- hdl/rws_pkg.sv -----
// Package for the roulette wheel selector: sequencer state type, field widths
// and fixed constants shared by the top level and the testbench.
// No dependencies.
`default_nettype none

package rws_pkg;

    localparam int unsigned FUNC_W    = 1;
    localparam int unsigned INDEX_W   = 5;
    localparam int unsigned WEIGHT_W  = 8;
    localparam int unsigned PERCENT_W = 7;
    localparam int unsigned POP_W     = 6;
    localparam int unsigned TOTAL_W   = 13;
    localparam int unsigned TARGET_W  = PERCENT_W + TOTAL_W;

    localparam logic [POP_W-1:0]     POP_RESET    = 6'd20;
    localparam logic [PERCENT_W-1:0] PERCENT_FULL = 7'd100;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_DRAW  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WR_UPD,
        ST_SCAN,
        ST_DONE
    } rws_state_t;

endpackage

`default_nettype wire

// ----- hdl/rws_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the weight table.
`default_nettype none

module rws_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/roulette_wheel_selector.sv -----
// Roulette wheel selector: weight table, running total and draw sequencer.
// Depends on rws_pkg and rws_ram.
//
// Use: requests arrive on the s_ channel (valid/ready). A write request
// (func 0) stores a weight and updates the running total; it gives no result.
// A draw request (func 1) scans the table from entry 0, one entry per cycle
// through the table RAM's read port, and returns the first entry whose
// running sum reaches draw_percent hundredths of the total on the m_ channel.
// found is 0, with index and weight 0, when no entry qualifies.
// Sequence: a write passes through ST_WR_UPD back to idle. A draw checks up
// to N entries, N being population_size capped at POP_ENTRIES, fewer if an
// early entry qualifies, and none when the total or population is zero.
// The scan rate is set by the single RAM read port and the one accumulator.
// The result sits in an output register; a new request is taken while it
// waits, but a draw that finishes before it is taken holds in its last state.
// Reset: all weights read as zero (per-entry valid flags), total zero,
// population_size 20, output empty. No clearing pass is needed.
// cfg_we writes population_size at once; do so only while the block is idle.
`default_nettype none

module roulette_wheel_selector #(
    parameter int unsigned POP_ENTRIES = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [rws_pkg::POP_W-1:0]         cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [rws_pkg::FUNC_W-1:0]        s_func,
    input  wire logic [rws_pkg::INDEX_W-1:0]       s_entry_index,
    input  wire logic [rws_pkg::WEIGHT_W-1:0]      s_weight,
    input  wire logic [rws_pkg::PERCENT_W-1:0]     s_draw_percent,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [rws_pkg::INDEX_W-1:0]       m_picked_index,
    output logic      [rws_pkg::WEIGHT_W-1:0]      m_picked_weight,
    output logic                                   m_found
);

    localparam int unsigned AW     = $clog2(POP_ENTRIES);
    localparam int unsigned CW     = $clog2(POP_ENTRIES + 1);
    localparam int unsigned SPW    = $clog2(POP_ENTRIES * 255 * 100 + 1);
    localparam int unsigned CMP_W  = (SPW > rws_pkg::TARGET_W) ? SPW : rws_pkg::TARGET_W;

    rws_pkg::rws_state_t state_reg, state_next;

    logic [POP_ENTRIES-1:0]             valid_reg, valid_next;
    logic                               valid_rd_reg;
    logic [rws_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic [rws_pkg::POP_W-1:0]          pop_reg, pop_next;
    logic [AW-1:0]                      idx_reg, idx_next;
    logic [rws_pkg::WEIGHT_W-1:0]       wt_reg, wt_next;
    logic                               in_range_reg, in_range_next;
    logic [rws_pkg::TARGET_W-1:0]       target_reg, target_next;
    logic [CMP_W-1:0]                   sp_reg, sp_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic [CW-1:0]                      issue_reg, issue_next;
    logic [CW-1:0]                      chk_reg, chk_next;
    logic                               res_found_reg, res_found_next;
    logic [rws_pkg::INDEX_W-1:0]        res_idx_reg, res_idx_next;
    logic [rws_pkg::WEIGHT_W-1:0]       res_wt_reg, res_wt_next;
    logic                               m_valid_reg, m_valid_next;
    logic [rws_pkg::INDEX_W-1:0]        m_idx_reg, m_idx_next;
    logic [rws_pkg::WEIGHT_W-1:0]       m_wt_reg, m_wt_next;
    logic                               m_found_reg, m_found_next;

    logic                               ram_we;
    logic [AW-1:0]                      rd_addr;
    logic [rws_pkg::WEIGHT_W-1:0]       rd_data;
    logic [rws_pkg::WEIGHT_W-1:0]       rd_weight;
    logic [CW-1:0]                      cnt_sat;
    logic [CMP_W-1:0]                   sp_sum;
    logic                               hit;
    logic                               last;
    logic                               out_free;
    logic                               accept;
    logic                               req_write;

    rws_ram #(
        .DATA_W (rws_pkg::WEIGHT_W),
        .DEPTH  (POP_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (wt_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // An entry never written since reset reads as zero.
    assign rd_weight = valid_rd_reg ? rd_data : '0;
    assign sp_sum    = sp_reg + CMP_W'(rd_weight) * CMP_W'(rws_pkg::PERCENT_FULL);
    assign hit       = sp_sum >= CMP_W'(target_reg);
    assign last      = chk_reg == (cnt_reg - CW'(1));
    assign out_free  = !m_valid_reg || m_ready;
    assign cnt_sat   = (int'(pop_reg) > int'(POP_ENTRIES)) ? CW'(POP_ENTRIES) : CW'(pop_reg);
    assign req_write = s_func == rws_pkg::FUNC_WRITE;
    assign accept    = s_valid && s_ready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rws_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (req_write) begin
                        state_next = rws_pkg::ST_WR_UPD;
                    end else if (total_reg == '0 || cnt_sat == '0) begin
                        state_next = rws_pkg::ST_DONE;
                    end else begin
                        state_next = rws_pkg::ST_SCAN;
                    end
                end
            end
            rws_pkg::ST_WR_UPD: begin
                state_next = rws_pkg::ST_IDLE;
            end
            rws_pkg::ST_SCAN: begin
                if (hit || last) begin
                    state_next = rws_pkg::ST_DONE;
                end
            end
            rws_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rws_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rws_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        s_ready        = 1'b0;
        ram_we         = 1'b0;
        rd_addr        = '0;
        valid_next     = valid_reg;
        total_next     = total_reg;
        pop_next       = cfg_we ? cfg_wdata : pop_reg;
        idx_next       = idx_reg;
        wt_next        = wt_reg;
        in_range_next  = in_range_reg;
        target_next    = target_reg;
        sp_next        = sp_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        chk_next       = chk_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        res_wt_next    = res_wt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_idx_next     = m_idx_reg;
        m_wt_next      = m_wt_reg;
        m_found_next   = m_found_reg;

        case (state_reg)
            rws_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                // Writes read the old weight; draws start the scan at entry 0.
                rd_addr = req_write ? AW'(s_entry_index) : '0;
                if (accept) begin
                    idx_next       = AW'(s_entry_index);
                    wt_next        = s_weight;
                    in_range_next  = int'(s_entry_index) < int'(POP_ENTRIES);
                    target_next    = rws_pkg::TARGET_W'(s_draw_percent)
                                     * rws_pkg::TARGET_W'(total_reg);
                    sp_next        = '0;
                    cnt_next       = cnt_sat;
                    issue_next     = CW'(1);
                    chk_next       = '0;
                    res_found_next = 1'b0;
                    res_idx_next   = '0;
                    res_wt_next    = '0;
                end
            end
            rws_pkg::ST_WR_UPD: begin
                if (in_range_reg) begin
                    ram_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    total_next          = total_reg - rws_pkg::TOTAL_W'(rd_weight)
                                          + rws_pkg::TOTAL_W'(wt_reg);
                end
            end
            rws_pkg::ST_SCAN: begin
                // Read of the next entry overlaps the check of the current one.
                rd_addr    = (issue_reg < cnt_reg) ? issue_reg[AW-1:0] : '0;
                issue_next = issue_reg + CW'(1);
                chk_next   = chk_reg + CW'(1);
                sp_next    = sp_sum;
                if (hit) begin
                    res_found_next = 1'b1;
                    res_idx_next   = rws_pkg::INDEX_W'(chk_reg);
                    res_wt_next    = rd_weight;
                end
            end
            rws_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    m_wt_next    = res_wt_reg;
                    m_found_next = res_found_reg;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rws_pkg::ST_IDLE;
            valid_reg   <= '0;
            total_reg   <= '0;
            pop_reg     <= rws_pkg::POP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            total_reg   <= total_next;
            pop_reg     <= pop_next;
            m_valid_reg <= m_valid_next;
        end
        valid_rd_reg  <= valid_reg[rd_addr];
        idx_reg       <= idx_next;
        wt_reg        <= wt_next;
        in_range_reg  <= in_range_next;
        target_reg    <= target_next;
        sp_reg        <= sp_next;
        cnt_reg       <= cnt_next;
        issue_reg     <= issue_next;
        chk_reg       <= chk_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        res_wt_reg    <= res_wt_next;
        m_idx_reg     <= m_idx_next;
        m_wt_reg      <= m_wt_next;
        m_found_reg   <= m_found_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_picked_index  = m_idx_reg;
    assign m_picked_weight = m_wt_reg;
    assign m_found         = m_found_reg;

    // A miss always carries a zero index and weight.
    a_miss_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_picked_index == '0 && m_picked_weight == '0))
        else $error("miss result with non-zero payload");

    // The scan never checks beyond the population.
    a_scan_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rws_pkg::ST_SCAN) |-> (chk_reg < cnt_reg))
        else $error("scan index beyond population");

    // A finished draw is presented as soon as the output register is free.
    a_done_loads : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rws_pkg::ST_DONE && out_free) |=> m_valid)
        else $error("finished draw not presented");

endmodule

`default_nettype wire

// ----- tb/sv/roulette_wheel_selector_test.sv -----
// Self-checking testbench for roulette_wheel_selector: directed and random weight
// writes and draws, checked against an in-bench model of the table and total.
// Depends on rws_pkg and the roulette_wheel_selector RTL.
module roulette_wheel_selector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POP_ENTRIES  = 32;
    localparam int unsigned DRAIN_CYCLES = 48;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [rws_pkg::FUNC_W-1:0]    func;
        logic [rws_pkg::INDEX_W-1:0]   entry_index;
        logic [rws_pkg::WEIGHT_W-1:0]  weight;
        logic [rws_pkg::PERCENT_W-1:0] draw_percent;
        logic                          drain_first;
    } wheel_req_t;

    typedef struct packed {
        logic [rws_pkg::INDEX_W-1:0]  picked_index;
        logic [rws_pkg::WEIGHT_W-1:0] picked_weight;
        logic                         found;
    } pick_t;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_we         = 1'b0;
    logic [rws_pkg::POP_W-1:0]     cfg_wdata      = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [rws_pkg::FUNC_W-1:0]    s_func         = rws_pkg::FUNC_WRITE;
    logic [rws_pkg::INDEX_W-1:0]   s_entry_index  = '0;
    logic [rws_pkg::WEIGHT_W-1:0]  s_weight       = '0;
    logic [rws_pkg::PERCENT_W-1:0] s_draw_percent = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [rws_pkg::INDEX_W-1:0]   m_picked_index;
    logic [rws_pkg::WEIGHT_W-1:0]  m_picked_weight;
    logic                          m_found;

    // Model of the block's state
    logic [rws_pkg::WEIGHT_W-1:0] weight_model [POP_ENTRIES];
    logic [rws_pkg::TOTAL_W-1:0]  total_model = '0;
    logic [rws_pkg::POP_W-1:0]    pop_model   = rws_pkg::POP_RESET;

    wheel_req_t  req_queue [$];
    pick_t       pending_picks [$];
    wheel_req_t  cur_req = '0;
    bit          req_taken = 1'b0;
    bit          sender_gaps_on = 1'b1;
    bit          receiver_stalls_on = 1'b1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned n_writes = 0;
    int unsigned n_draws = 0;
    int unsigned n_hits = 0;
    int unsigned n_settings = 1;

    roulette_wheel_selector #(
        .POP_ENTRIES(POP_ENTRIES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_entry_index  (s_entry_index),
        .s_weight       (s_weight),
        .s_draw_percent (s_draw_percent),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_picked_index (m_picked_index),
        .m_picked_weight(m_picked_weight),
        .m_found        (m_found)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < POP_ENTRIES; i++) begin
            weight_model[i] = '0;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Updates the table on a write; works out the pick for a draw.
    task automatic apply_request(input wheel_req_t req);
        int unsigned scan_len;
        int unsigned threshold;
        int unsigned running;
        pick_t       pick;
        pick = '0;
        if (req.func == rws_pkg::FUNC_WRITE) begin
            total_model = total_model - weight_model[req.entry_index] + req.weight;
            weight_model[req.entry_index] = req.weight;
            n_writes++;
        end else begin
            scan_len  = (pop_model > POP_ENTRIES) ? POP_ENTRIES : 32'(pop_model);
            threshold = 32'(req.draw_percent) * 32'(total_model);
            running   = 0;
            if (total_model != 0) begin
                for (int i = 0; i < scan_len; i++) begin
                    if (!pick.found) begin
                        running += 32'(weight_model[i]);
                        if (32'(rws_pkg::PERCENT_FULL) * running >= threshold) begin
                            pick.found         = 1'b1;
                            pick.picked_index  = i[rws_pkg::INDEX_W-1:0];
                            pick.picked_weight = weight_model[i];
                        end
                    end
                end
            end
            pending_picks.push_back(pick);
            n_draws++;
            if (pick.found) n_hits++;
        end
    endtask

    // Acceptance of requests and checking of results, both at the rising edge.
    always @(posedge aclk) begin : monitor_proc
        pick_t got;
        pick_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.picked_index  = m_picked_index;
                got.picked_weight = m_picked_weight;
                got.found         = m_found;
                if (pending_picks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"[%0t] result with no draw outstanding: ",
                                  "index %0d weight %0d found %0b"},
                                 $time, got.picked_index, got.picked_weight, got.found);
                end else begin
                    want = pending_picks.pop_front();
                    if (got.found !== want.found || got.picked_index !== want.picked_index ||
                        got.picked_weight !== want.picked_weight) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"[%0t] mismatch: expected index %0d weight %0d ",
                                      "found %0b, got index %0d weight %0d found %0b"},
                                     $time, want.picked_index, want.picked_weight,
                                     want.found, got.picked_index, got.picked_weight,
                                     got.found);
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_request(cur_req);
                req_taken = 1'b1;
            end
        end
    end

    // Request driver: holds a request until it is taken, then pauses at random.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (req_taken) begin
                req_taken = 1'b0;
                if (sender_gaps_on) gap_left = pick_gap();
            end
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (req_queue.size() != 0 &&
                         !(req_queue[0].drain_first && pending_picks.size() != 0)) begin
                cur_req = req_queue.pop_front();
                s_func         <= cur_req.func;
                s_entry_index  <= cur_req.entry_index;
                s_weight       <= cur_req.weight;
                s_draw_percent <= cur_req.draw_percent;
                s_valid        <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver with random back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (receiver_stalls_on) stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("roulette_wheel_selector verification failed");
            $finish;
        end
    end

    task automatic push_write(input int unsigned idx, input int unsigned w);
        wheel_req_t req;
        req = '0;
        req.func        = rws_pkg::FUNC_WRITE;
        req.entry_index = idx[rws_pkg::INDEX_W-1:0];
        req.weight      = w[rws_pkg::WEIGHT_W-1:0];
        req_queue.push_back(req);
    endtask

    task automatic push_draw(input int unsigned pct, input bit drain);
        wheel_req_t req;
        req = '0;
        req.func         = rws_pkg::FUNC_DRAW;
        req.draw_percent = pct[rws_pkg::PERCENT_W-1:0];
        req.drain_first  = drain;
        req_queue.push_back(req);
    endtask

    // Waits until every request is taken, every result has come and the
    // block has had time to finish any write still in progress.
    task automatic settle();
        @(posedge aclk);
        while (req_queue.size() != 0 || s_valid) @(posedge aclk);
        @(negedge aclk);
        while (pending_picks.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic begin_phase(input logic [rws_pkg::POP_W-1:0] pop, input bit idling);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= pop;
        pop_model  = pop;
        n_settings++;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        sender_gaps_on     = idling;
        receiver_stalls_on = idling;
    endtask

    task automatic push_random_mix(input int unsigned count);
        int unsigned span;
        int unsigned r;
        wheel_req_t  req;
        span = (pop_model == 0) ? 1 :
               ((pop_model > POP_ENTRIES) ? POP_ENTRIES : 32'(pop_model));
        for (int unsigned n = 0; n < count; n++) begin
            // Unused fields get random values too.
            req.entry_index  = rws_pkg::INDEX_W'($urandom_range(0, 31));
            req.weight       = rws_pkg::WEIGHT_W'($urandom_range(0, 255));
            req.draw_percent = rws_pkg::PERCENT_W'($urandom_range(0, 127));
            req.drain_first  = ($urandom_range(0, 99) < 2);
            if ($urandom_range(0, 99) < 40) begin
                req.func = rws_pkg::FUNC_WRITE;
                if ($urandom_range(0, 9) < 7)
                    req.entry_index = rws_pkg::INDEX_W'($urandom_range(0, span - 1));
                r = $urandom_range(0, 99);
                if (r < 20) req.weight = 8'd0;
                else if (r < 30) req.weight = 8'd255;
            end else begin
                req.func = rws_pkg::FUNC_DRAW;
                r = $urandom_range(0, 99);
                if (r < 8) req.draw_percent = 7'd0;
                else if (r < 18) req.draw_percent = rws_pkg::PERCENT_FULL;
                else if (r < 28)
                    req.draw_percent = rws_pkg::PERCENT_W'($urandom_range(101, 127));
                else req.draw_percent = rws_pkg::PERCENT_W'($urandom_range(1, 99));
            end
            req_queue.push_back(req);
        end
    endtask

    initial begin : stimulus
        logic [rws_pkg::POP_W-1:0] pop_plan [10];
        pop_plan = '{6'd20, 6'd32, 6'd1, 6'd63, 6'd2, 6'd0, 6'd33, 6'd16, 6'd0, 6'd0};
        pop_plan[8] = rws_pkg::POP_W'($urandom_range(3, 31));
        pop_plan[9] = rws_pkg::POP_W'($urandom_range(1, 63));

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset population of 20; the first draw sees an empty table.
        push_draw(50, 1'b0);
        push_write(0, 0);
        push_write(31, 255);
        push_write(5, 128);
        push_draw(0, 1'b0);
        push_draw(1, 1'b0);
        push_draw(100, 1'b0);     // qualifying entry lies beyond the population
        push_draw(127, 1'b0);
        push_write(5, 255);       // overwrite: total drops the old weight
        push_draw(33, 1'b0);

        begin_phase(6'd32, 1'b1);
        push_draw(100, 1'b0);
        push_draw(99, 1'b0);

        begin_phase(6'd63, 1'b1);  // saturates at the table size
        push_draw(100, 1'b0);
        push_draw(50, 1'b0);

        begin_phase(6'd0, 1'b1);
        push_draw(50, 1'b0);
        push_draw(0, 1'b0);

        begin_phase(6'd1, 1'b0);
        push_draw(0, 1'b0);
        push_write(0, 255);
        push_draw(1, 1'b1);
        push_draw(100, 1'b0);

        for (int p = 0; p < 10; p++) begin
            begin_phase(pop_plan[p], (p % 4) != 2);
            if (p == 3) begin
                // Clear the whole table, draw against a zero total, then refill.
                for (int i = 0; i < POP_ENTRIES; i++) push_write(i, 0);
                for (int i = 0; i < 6; i++) push_draw($urandom_range(0, 127), 1'b0);
                push_random_mix(87);
            end else begin
                push_random_mix(125);
            end
        end

        settle();
        $display({"Covered %0d weight writes and %0d draws (%0d picks, %0d empty) ",
                  "over %0d population settings."},
                 n_writes, n_draws, n_hits, n_draws - n_hits, n_settings);
        if (fail_count == 0) begin
            $display("roulette_wheel_selector verification clean");
        end else begin
            $display("%0d result failures", fail_count);
            $display("roulette_wheel_selector verification failed");
        end
        $finish;
    end

endmodule

// ----- roulette_wheel_selector.f -----
hdl/rws_pkg.sv
hdl/rws_ram.sv
hdl/roulette_wheel_selector.sv
tb/sv/roulette_wheel_selector_test.sv
